// ===== src/mmb_pkg.sv =====
package mmb_pkg;

    // Default widths of the fixed-point format and of the binary angles.
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // Rotation-mode CORDIC constants: step count, step index width, and the gain and pi/2 in Q2.30.
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [30:0]        HALF_PI_Q30     = 31'd1686629713;

    // Update kinds carried by an input word.
    localparam logic [1:0] KIND_ROT   = 2'd0;
    localparam logic [1:0] KIND_TRANS = 2'd1;
    localparam logic [1:0] KIND_SCALE = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Product job sequence: scale updates, rotation terms, then three per row.
    localparam int JOB_W = 5;
    localparam logic [JOB_W-1:0] JOB_SCALE_LAST = 5'd2;
    localparam logic [JOB_W-1:0] JOB_ROT_FIRST  = 5'd3;
    localparam logic [JOB_W-1:0] JOB_ROW0_LAST  = 5'd19;
    localparam logic [JOB_W-1:0] JOB_ROW1_LAST  = 5'd22;
    localparam logic [JOB_W-1:0] JOB_ROW2_LAST  = 5'd25;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [1:0] ROW_PENULT = 2'd2;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_MUL_ISSUE,
        OP_MUL_WB,
        OP_RESID,
        OP_CINIT,
        OP_CSTEP,
        OP_CDONE,
        OP_LOAD
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_ISSUE,
        S_MUL_WB,
        S_TRIG_MUL,
        S_TRIG_INIT,
        S_CORDIC,
        S_TRIG_DONE,
        S_LOAD
    } state_t;

    typedef enum logic [4:0] {
        OPD_SCALE0, OPD_SCALE1, OPD_SCALE2,
        OPD_VAL0, OPD_VAL1, OPD_VAL2,
        OPD_CX, OPD_SX, OPD_CY, OPD_SY, OPD_CZ, OPD_SZ,
        OPD_SYX, OPD_CYX,
        OPD_ROT00, OPD_ROT01, OPD_ROT02,
        OPD_ROT10, OPD_ROT11, OPD_ROT12,
        OPD_ROT20, OPD_ROT21, OPD_ROT22,
        OPD_RESID, OPD_HALFPI
    } opnd_t;

    typedef enum logic [4:0] {
        DST_NONE,
        DST_SCALE0, DST_SCALE1, DST_SCALE2,
        DST_SYX, DST_CYX,
        DST_ROT00, DST_ROT01, DST_ROT02,
        DST_ROT10, DST_ROT11,
        DST_ROT20, DST_ROT21, DST_ROT22,
        DST_E0, DST_E1, DST_E2
    } dst_t;

    typedef enum logic [1:0] {
        MD_WR,
        MD_ADD,
        MD_SUB
    } mode_t;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
        dst_t  dst;
        mode_t mode;
    } job_t;

    typedef struct packed {
        op_t              op;
        logic [JOB_W-1:0] job;
        logic [1:0]       sel;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic item_skip;
    } status_t;

    function automatic job_t job_entry(input logic [JOB_W-1:0] j);
        job_t e;
        case (j)
            5'd0:  e = '{OPD_SCALE0, OPD_VAL0, DST_SCALE0, MD_WR};
            5'd1:  e = '{OPD_SCALE1, OPD_VAL1, DST_SCALE1, MD_WR};
            5'd2:  e = '{OPD_SCALE2, OPD_VAL2, DST_SCALE2, MD_WR};
            5'd3:  e = '{OPD_SY, OPD_SX, DST_SYX, MD_WR};
            5'd4:  e = '{OPD_CY, OPD_SX, DST_CYX, MD_WR};
            5'd5:  e = '{OPD_CY, OPD_CZ, DST_ROT00, MD_WR};
            5'd6:  e = '{OPD_SYX, OPD_SZ, DST_ROT00, MD_ADD};
            5'd7:  e = '{OPD_SYX, OPD_CZ, DST_ROT01, MD_WR};
            5'd8:  e = '{OPD_CY, OPD_SZ, DST_ROT01, MD_SUB};
            5'd9:  e = '{OPD_SY, OPD_CX, DST_ROT02, MD_WR};
            5'd10: e = '{OPD_CX, OPD_SZ, DST_ROT10, MD_WR};
            5'd11: e = '{OPD_CX, OPD_CZ, DST_ROT11, MD_WR};
            5'd12: e = '{OPD_CYX, OPD_SZ, DST_ROT20, MD_WR};
            5'd13: e = '{OPD_SY, OPD_CZ, DST_ROT20, MD_SUB};
            5'd14: e = '{OPD_SY, OPD_SZ, DST_ROT21, MD_WR};
            5'd15: e = '{OPD_CYX, OPD_CZ, DST_ROT21, MD_ADD};
            5'd16: e = '{OPD_CY, OPD_CX, DST_ROT22, MD_WR};
            5'd17: e = '{OPD_SCALE0, OPD_ROT00, DST_E0, MD_WR};
            5'd18: e = '{OPD_SCALE0, OPD_ROT01, DST_E1, MD_WR};
            5'd19: e = '{OPD_SCALE0, OPD_ROT02, DST_E2, MD_WR};
            5'd20: e = '{OPD_SCALE1, OPD_ROT10, DST_E0, MD_WR};
            5'd21: e = '{OPD_SCALE1, OPD_ROT11, DST_E1, MD_WR};
            5'd22: e = '{OPD_SCALE1, OPD_ROT12, DST_E2, MD_WR};
            5'd23: e = '{OPD_SCALE2, OPD_ROT20, DST_E0, MD_WR};
            5'd24: e = '{OPD_SCALE2, OPD_ROT21, DST_E1, MD_WR};
            5'd25: e = '{OPD_SCALE2, OPD_ROT22, DST_E2, MD_WR};
            default: e = '{OPD_SCALE0, OPD_SCALE0, DST_NONE, MD_WR};
        endcase
        return e;
    endfunction

    function automatic logic signed [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [31:0] a;
        case (i)
            5'd0:  a = 32'sh3243F6A8;
            5'd1:  a = 32'sh1DAC6705;
            5'd2:  a = 32'sh0FADBAFC;
            5'd3:  a = 32'sh07F56EA6;
            5'd4:  a = 32'sh03FEAB76;
            5'd5:  a = 32'sh01FFD55B;
            5'd6:  a = 32'sh00FFFAAA;
            5'd7:  a = 32'sh007FFF55;
            5'd8:  a = 32'sh003FFFEA;
            5'd9:  a = 32'sh001FFFFD;
            5'd10: a = 32'sh000FFFFF;
            5'd11: a = 32'sh0007FFFF;
            5'd12: a = 32'sh0003FFFF;
            5'd13: a = 32'sh0001FFFF;
            5'd14: a = 32'sh0000FFFF;
            5'd15: a = 32'sh00007FFF;
            5'd16: a = 32'sh00003FFF;
            5'd17: a = 32'sh00001FFF;
            5'd18: a = 32'sh00000FFF;
            5'd19: a = 32'sh000007FF;
            5'd20: a = 32'sh000003FF;
            5'd21: a = 32'sh000001FF;
            5'd22: a = 32'sh000000FF;
            5'd23: a = 32'sh0000007F;
            5'd24: a = 32'sh0000003F;
            5'd25: a = 32'sh0000001F;
            5'd26: a = 32'sh0000000F;
            5'd27: a = 32'sh00000008;
            5'd28: a = 32'sh00000004;
            5'd29: a = 32'sh00000002;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

endpackage

// ===== src/mmb_ctrl.sv =====
module mmb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mmb_pkg::status_t status,
    output mmb_pkg::cmd_t    cmd
);
    import mmb_pkg::*;

    state_t            state_reg, state_next;
    logic [JOB_W-1:0]  job_reg, job_next;
    logic [1:0]        axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= '0;
            axis_reg  <= '0;
            step_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !status.item_skip)
                begin
                    state_next = S_MUL_ISSUE;
                    job_next   = '0;
                    axis_next  = '0;
                    row_next   = '0;
                end
            end
            S_MUL_ISSUE:
            begin
                state_next = S_MUL_WB;
            end
            S_MUL_WB:
            begin
                if (job_reg == JOB_SCALE_LAST)
                begin
                    state_next = S_TRIG_MUL;
                end
                else if (job_reg == JOB_ROW0_LAST || job_reg == JOB_ROW1_LAST ||
                         job_reg == JOB_ROW2_LAST)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_MUL_ISSUE;
                    job_next   = job_reg + 1'b1;
                end
            end
            S_TRIG_MUL:
            begin
                state_next = S_TRIG_INIT;
            end
            S_TRIG_INIT:
            begin
                state_next = S_CORDIC;
                step_next  = '0;
            end
            S_CORDIC:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_TRIG_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_TRIG_DONE:
            begin
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = S_MUL_ISSUE;
                    job_next   = JOB_ROT_FIRST;
                end
                else
                begin
                    state_next = S_TRIG_MUL;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    row_next = row_reg + 1'b1;
                    if (row_reg == ROW_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (row_reg == ROW_PENULT)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_MUL_ISSUE;
                        job_next   = job_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        item_ready = 1'b0;
        cmd.op     = OP_NONE;
        cmd.job    = job_reg;
        cmd.sel    = axis_reg;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid && !status.item_skip)
                begin
                    cmd.op = OP_LATCH;
                end
            end
            S_MUL_ISSUE: cmd.op = OP_MUL_ISSUE;
            S_MUL_WB:    cmd.op = OP_MUL_WB;
            S_TRIG_MUL:  cmd.op = OP_RESID;
            S_TRIG_INIT: cmd.op = OP_CINIT;
            S_CORDIC:    cmd.op = OP_CSTEP;
            S_TRIG_DONE: cmd.op = OP_CDONE;
            S_LOAD:
            begin
                cmd.sel = row_reg;
                if (status.out_free)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== src/mmb_datapath.sv =====
module mmb_datapath #(
    parameter int FRAC_BITS  = mmb_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = mmb_pkg::ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mmb_pkg::in_word_t  item,
    output mmb_pkg::out_word_t row,
    output logic               row_valid,
    input  logic               row_ready,
    input  mmb_pkg::cmd_t      cmd,
    output mmb_pkg::status_t   status
);
    import mmb_pkg::*;

    localparam int OW = 34;
    localparam int PW = 2 * OW;
    localparam logic signed [PW-1:0] RND    = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] RND30  = PW'(1) << 29;
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [31:0]   ONE_Q  = 32'(1) << FRAC_BITS;
    localparam logic signed [31:0]   RND_Q  = 32'(1) << (29 - FRAC_BITS);
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [1:0]            kind_reg;
    logic signed [31:0]    val_reg [3];
    logic signed [31:0]    pos_reg [3];
    logic [ANGLE_BITS-1:0] ang_reg [3];
    logic signed [31:0]    scale_reg [3];
    logic signed [31:0]    cos_reg [3];
    logic signed [31:0]    sin_reg [3];
    logic signed [31:0]    syx_reg, cyx_reg;
    logic signed [OW-1:0]  rot00_reg, rot01_reg, rot02_reg;
    logic signed [OW-1:0]  rot10_reg, rot11_reg;
    logic signed [OW-1:0]  rot20_reg, rot21_reg, rot22_reg;
    logic signed [31:0]    e_reg [3];
    logic signed [PW-1:0]  prod_reg;
    logic signed [31:0]    cx_reg, cy_reg, cz_reg;
    out_word_t             row_reg;
    logic                  row_valid_reg;

    logic signed [31:0] in_val [3];
    job_t               job;
    opnd_t              sel_a, sel_b;
    logic signed [31:0] q;
    logic [29:0]        resid;
    logic signed [31:0] xq, yq;

    assign in_val[0] = item.value_x;
    assign in_val[1] = item.value_y;
    assign in_val[2] = item.value_z;

    function automatic logic signed [OW-1:0] sx34(input logic signed [31:0] v);
        return {{(OW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + RND) >>> FRAC_BITS;
        if (t > SAT_HI)
            return 32'sh7FFFFFFF;
        else if (t < SAT_LO)
            return 32'sh80000000;
        return t[31:0];
    endfunction

    function automatic logic signed [31:0] q30_to_q(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = ($signed({v[31], v}) + $signed({RND_Q[31], RND_Q})) >>> (30 - FRAC_BITS);
        return t[31:0];
    endfunction

    function automatic logic signed [OW-1:0] operand(input opnd_t o);
        logic signed [OW-1:0] r;
        case (o)
            OPD_SCALE0: r = sx34(scale_reg[0]);
            OPD_SCALE1: r = sx34(scale_reg[1]);
            OPD_SCALE2: r = sx34(scale_reg[2]);
            OPD_VAL0:   r = sx34(val_reg[0]);
            OPD_VAL1:   r = sx34(val_reg[1]);
            OPD_VAL2:   r = sx34(val_reg[2]);
            OPD_CX:     r = sx34(cos_reg[0]);
            OPD_SX:     r = sx34(sin_reg[0]);
            OPD_CY:     r = sx34(cos_reg[1]);
            OPD_SY:     r = sx34(sin_reg[1]);
            OPD_CZ:     r = sx34(cos_reg[2]);
            OPD_SZ:     r = sx34(sin_reg[2]);
            OPD_SYX:    r = sx34(syx_reg);
            OPD_CYX:    r = sx34(cyx_reg);
            OPD_ROT00:  r = rot00_reg;
            OPD_ROT01:  r = rot01_reg;
            OPD_ROT02:  r = rot02_reg;
            OPD_ROT10:  r = rot10_reg;
            OPD_ROT11:  r = rot11_reg;
            OPD_ROT12:  r = -sx34(sin_reg[0]);
            OPD_ROT20:  r = rot20_reg;
            OPD_ROT21:  r = rot21_reg;
            OPD_ROT22:  r = rot22_reg;
            OPD_RESID:  r = {{(OW-30){1'b0}}, resid};
            OPD_HALFPI: r = {{(OW-31){1'b0}}, HALF_PI_Q30};
            default:    r = '0;
        endcase
        return r;
    endfunction

    // The part of the turn below the quadrant, as a 30-bit fraction.
    assign resid = {ang_reg[cmd.sel][ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)};

    assign job   = job_entry(cmd.job);
    assign sel_a = (cmd.op == OP_RESID) ? OPD_RESID  : job.a;
    assign sel_b = (cmd.op == OP_RESID) ? OPD_HALFPI : job.b;
    assign q     = round_sat(prod_reg);
    assign xq    = q30_to_q(cx_reg);
    assign yq    = q30_to_q(cy_reg);

    // Shared multiplier, always registered.
    always_ff @(posedge clk)
    begin
        prod_reg <= operand(sel_a) * operand(sel_b);
    end

    // Pose accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]   <= '0;
                ang_reg[i]   <= '0;
                scale_reg[i] <= ONE_Q;
            end
        end
        else if (cmd.op == OP_LATCH)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (item.kind == KIND_ROT)
                begin
                    ang_reg[i] <= ang_reg[i] + in_val[i][ANGLE_BITS-1:0];
                end
                else if (item.kind == KIND_TRANS)
                begin
                    logic signed [32:0] s;
                    s = {pos_reg[i][31], pos_reg[i]} + {in_val[i][31], in_val[i]};
                    if (s[32] != s[31])
                        pos_reg[i] <= s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                    else
                        pos_reg[i] <= s[31:0];
                end
            end
        end
        else if (cmd.op == OP_MUL_WB && kind_reg == KIND_SCALE)
        begin
            case (job.dst)
                DST_SCALE0: scale_reg[0] <= q;
                DST_SCALE1: scale_reg[1] <= q;
                DST_SCALE2: scale_reg[2] <= q;
                default:    ;
            endcase
        end
    end

    // Working registers of one update.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            kind_reg <= item.kind;
            for (int i = 0; i < 3; i++)
            begin
                val_reg[i] <= in_val[i];
            end
        end
        if (cmd.op == OP_MUL_WB)
        begin
            case (job.dst)
                DST_SYX:   syx_reg <= q;
                DST_CYX:   cyx_reg <= q;
                DST_ROT00: rot00_reg <= (job.mode == MD_ADD) ? rot00_reg + sx34(q) : sx34(q);
                DST_ROT01: rot01_reg <= (job.mode == MD_SUB) ? rot01_reg - sx34(q) : sx34(q);
                DST_ROT02: rot02_reg <= sx34(q);
                DST_ROT10: rot10_reg <= sx34(q);
                DST_ROT11: rot11_reg <= sx34(q);
                DST_ROT20: rot20_reg <= (job.mode == MD_SUB) ? rot20_reg - sx34(q) : sx34(q);
                DST_ROT21: rot21_reg <= (job.mode == MD_ADD) ? rot21_reg + sx34(q) : sx34(q);
                DST_ROT22: rot22_reg <= sx34(q);
                DST_E0:    e_reg[0] <= q;
                DST_E1:    e_reg[1] <= q;
                DST_E2:    e_reg[2] <= q;
                default:   ;
            endcase
        end
        case (cmd.op)
            OP_CINIT:
            begin
                logic signed [PW-1:0] zr;
                zr = (prod_reg + RND30) >>> 30;
                cz_reg <= zr[31:0];
                cx_reg <= CORDIC_GAIN_Q30;
                cy_reg <= '0;
            end
            OP_CSTEP:
            begin
                if (!cz_reg[31])
                begin
                    cx_reg <= cx_reg - (cy_reg >>> cmd.step);
                    cy_reg <= cy_reg + (cx_reg >>> cmd.step);
                    cz_reg <= cz_reg - atan_q30(cmd.step);
                end
                else
                begin
                    cx_reg <= cx_reg + (cy_reg >>> cmd.step);
                    cy_reg <= cy_reg - (cx_reg >>> cmd.step);
                    cz_reg <= cz_reg + atan_q30(cmd.step);
                end
            end
            OP_CDONE:
            begin
                case (ang_reg[cmd.sel][ANGLE_BITS-1:ANGLE_BITS-2])
                    QUAD_0:
                    begin
                        cos_reg[cmd.sel] <= xq;
                        sin_reg[cmd.sel] <= yq;
                    end
                    QUAD_1:
                    begin
                        cos_reg[cmd.sel] <= -yq;
                        sin_reg[cmd.sel] <= xq;
                    end
                    QUAD_2:
                    begin
                        cos_reg[cmd.sel] <= -xq;
                        sin_reg[cmd.sel] <= -yq;
                    end
                    default:
                    begin
                        cos_reg[cmd.sel] <= yq;
                        sin_reg[cmd.sel] <= -xq;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            row_valid_reg <= 1'b1;
        end
        else if (row_ready)
        begin
            row_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            row_reg.row_index <= cmd.sel;
            if (cmd.sel == ROW_LAST)
            begin
                row_reg.col0     <= '0;
                row_reg.col1     <= '0;
                row_reg.col2     <= '0;
                row_reg.col3     <= ONE_Q;
                row_reg.last_row <= 1'b1;
            end
            else
            begin
                row_reg.col0     <= e_reg[0];
                row_reg.col1     <= e_reg[1];
                row_reg.col2     <= e_reg[2];
                row_reg.col3     <= pos_reg[cmd.sel];
                row_reg.last_row <= 1'b0;
            end
        end
    end

    assign row              = row_reg;
    assign row_valid        = row_valid_reg;
    assign status.out_free  = !row_valid_reg || row_ready;
    assign status.item_skip = (item.kind == KIND_NONE);

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> status.out_free)
        else $error("row loaded while the output register is occupied");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(row_valid_reg) |-> $past(cmd.op == OP_LOAD))
        else $error("row valid rose without a load");

    a_cordic_steps_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CSTEP && cmd.step != '0) |->
            ($past(cmd.op == OP_CSTEP) && cmd.step == $past(cmd.step) + 1'b1))
        else $error("CORDIC step out of sequence");
`endif

endmodule

// ===== src/model_matrix_builder.sv =====
// Row 0 is valid after the scale, sine/cosine, rotation and row 0 products.
// A new update word is taken only once the last row of the previous one is loaded.
// A word with the unused kind is accepted and produces no rows.
// Reset (rst_n, asynchronous, active low) clears the pose to zero translation,
// zero angles and unit scale, and empties the output register.
module model_matrix_builder #(
    parameter int FRAC_BITS  = mmb_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = mmb_pkg::ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mmb_pkg::in_word_t  item,
    output logic               row_valid,
    input  logic               row_ready,
    output mmb_pkg::out_word_t row
);
    import mmb_pkg::*;

    // The controller sequences one update at a time. The work is bounded
    // by the single shared 34x34 multiplier (an issue and a write-back state
    // for each of the 26 jobs, one residual product for each angle) and by
    // the one CORDIC unit, which runs 30 iterations for each of the three
    // angles in turn.
    //
    // Order of work: scale products, the three sine/cosine pairs, the rotation
    // terms of Ry*Rx*Rz, then per row the three scaled elements, each row
    // handed to the output register as soon as that register is free. The
    // next update word is accepted once the constant last row is loaded, even
    // while it still waits to be taken.

    cmd_t    cmd;
    status_t status;

    mmb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    mmb_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .row       (row),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
